>>> hw/rtl/ttst_pkg.sv
// Shared types and constants for the task timing statistics table.
// No dependencies; imported by ttst_store and task_timing_stats_table.
`timescale 1ns / 1ps

package ttst_pkg;

   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int SLOT_FIELD_W = 4;
   localparam int CNT_W       = 5;
   localparam int MASK_W      = 16;
   localparam int AVG_SHIFT   = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 336;
   localparam int CSR_ADDR_W  = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_RECORD     = 3'd0;
   localparam logic [OP_W-1:0] OP_RESET_SLOT = 3'd1;
   localparam logic [OP_W-1:0] OP_RESET_ALL  = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_BUDGET = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_SLOT  = 3'd4;
   localparam logic [OP_W-1:0] OP_SUMMARY    = 3'd5;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_MASK = 3'd0;

   typedef struct packed {
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] last;
      logic [DATA_W-1:0] peak;
      logic [DATA_W-1:0] avg;
      logic [DATA_W-1:0] overrun;
   } ttst_stats_type;

   typedef struct packed {
      logic rd_en;
      logic st_wr;
      logic bud_wr;
      logic clr_one;
      logic clr_all;
   } ttst_ctl_type;

endpackage

>>> hw/rtl/task_timing_stats_table.sv
// Task timing statistics table, top level. Depends on ttst_pkg and ttst_store.
// Holds the sequencer, the shared subtractor, summary accumulators and ports.
//
// Usage:
//   req channel: tuser carries the operation, tdata the slot and the value.
//   rsp channel: one result transaction per request, the slot record and the
//   summary fields packed in tdata.
//   csr port: APB-style, one register (active_mask) at byte address 0.
// Sequencing:
//   Read slot, set budget, reset slot and reset all read the slot memory, then
//   load their result. Record reads the memory and subtracts for the average
//   step, then writes back and loads its result. Summary scans min(NUM_SLOTS,16)
//   slots, one slot per cycle through the shared subtractor, then loads its
//   result. The slot memory has a single read port. req_tready is high only
//   while the sequencer is idle, which it reaches as the result is loaded, so a
//   new request is not taken before the last one's result is loaded.
// Reset:
//   All statistics and budgets read as zero right after reset; per-slot valid
//   bits stand in for the memory contents, so there is no clearing pass.
//   active_mask returns to all ones.
// Stall:
//   The result register holds its transaction until rsp_tready; a new request
//   may be accepted meanwhile, and the sequencer waits to load its result.
`timescale 1ns / 1ps

module task_timing_stats_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ttst_pkg::REQ_TDATA_W-1:0]     req_tdata,  // slot[3:0], value[35:4]
   input  logic [ttst_pkg::OP_W-1:0]            req_tuser,  // operation[2:0]
   // rsp channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // sample_count[31:0], last_time[63:32], peak_time[95:64], average_time[127:96],
   // slot_overruns[159:128], budget_time[191:160], active_slots[196:192],
   // over_budget_slots[201:197], total_overruns[233:202], max_last_time[265:234],
   // budget_at_max_last[297:266], max_excess_time[329:298]
   output logic [ttst_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // csr port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ttst_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import ttst_pkg::*;

   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SCAN_N    = (NUM_SLOTS < MASK_W) ? NUM_SLOTS : MASK_W;
   localparam int SCAN_LAST = SCAN_N - 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_AVG  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_SUM  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [SLOT_FIELD_W-1:0] slot_ff, slot_in;
   logic [DATA_W-1:0]       val_ff, val_in;
   logic                    ok_ff, ok_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic [DATA_W-1:0]       diff_ff, diff_in;
   logic                    ge_ff, ge_in;
   logic [CNT_W-1:0]        act_ff, act_in;
   logic [CNT_W-1:0]        ovc_ff, ovc_in;
   logic [DATA_W-1:0]       tot_ff, tot_in;
   logic [DATA_W-1:0]       mxl_ff, mxl_in;
   logic [DATA_W-1:0]       mxb_ff, mxb_in;
   logic [DATA_W-1:0]       mxe_ff, mxe_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   ttst_ctl_type      ctl;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_addr;
   ttst_stats_type    wr_stats;
   ttst_stats_type    rd_stats;
   logic [DATA_W-1:0] rd_bud;

   logic [SLOT_FIELD_W-1:0] req_slot;
   logic [DATA_W-1:0]       req_value;
   logic                    req_fire;
   logic                    out_free;
   logic                    load_rsp;

   // shared subtractor: a - b with borrow
   logic [DATA_W-1:0] alu_a, alu_b;
   logic [DATA_W:0]   alu_res;
   logic              alu_borrow;

   ttst_stats_type    res_stats;
   logic [DATA_W-1:0] res_bud;
   logic [DATA_W-1:0] avg_step;
   logic [DATA_W-1:0] excess;
   logic              scan_over;
   logic [MASK_W-1:0] mask_sh;
   logic              csr_wr;

   assign req_slot   = req_tdata[SLOT_FIELD_W-1:0];
   assign req_value  = req_tdata[SLOT_FIELD_W +: DATA_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wr_addr    = SLOT_W'(slot_ff);

   assign alu_a      = (state_ff == ST_SCAN) ? rd_stats.last : val_ff;
   assign alu_b      = (state_ff == ST_SCAN) ? rd_bud : rd_stats.avg;
   assign alu_res    = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_res[DATA_W];

   assign avg_step   = diff_ff >> AVG_SHIFT;
   assign mask_sh    = mask_ff >> idx_ff;
   assign scan_over  = (rd_bud != '0) && !alu_borrow && (alu_res[DATA_W-1:0] != '0);
   assign excess     = scan_over ? alu_res[DATA_W-1:0] : '0;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      slot_in   = slot_ff;
      val_in    = val_ff;
      ok_in     = ok_ff;
      idx_in    = idx_ff;
      diff_in   = diff_ff;
      ge_in     = ge_ff;
      act_in    = act_ff;
      ovc_in    = ovc_ff;
      tot_in    = tot_ff;
      mxl_in    = mxl_ff;
      mxb_in    = mxb_ff;
      mxe_in    = mxe_ff;
      ctl       = '0;
      rd_addr   = '0;
      wr_stats  = rd_stats;
      load_rsp  = 1'b0;
      res_stats = '0;
      res_bud   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_tuser;
               slot_in = req_slot;
               val_in  = req_value;
               ok_in   = ({{(DATA_W-SLOT_FIELD_W){1'b0}}, req_slot} < DATA_W'(NUM_SLOTS));
               ctl.rd_en = 1'b1;
               if (req_tuser == OP_SUMMARY) begin
                  rd_addr  = '0;
                  idx_in   = '0;
                  act_in   = '0;
                  ovc_in   = '0;
                  tot_in   = '0;
                  mxl_in   = '0;
                  mxb_in   = '0;
                  mxe_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  rd_addr  = SLOT_W'(req_slot);
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            if (op_ff == OP_RECORD && ok_ff) begin
               ge_in    = !alu_borrow;
               diff_in  = alu_borrow ? (DATA_W'(0) - alu_res[DATA_W-1:0])
                                     : alu_res[DATA_W-1:0];
               state_in = ST_AVG;
            end else if (out_free) begin
               load_rsp    = 1'b1;
               state_in    = ST_IDLE;
               ctl.clr_all = (op_ff == OP_RESET_ALL);
               res_stats   = rd_stats;
               res_bud     = rd_bud;
               case (op_ff) inside
                  OP_RESET_SLOT, OP_RESET_ALL: begin
                     res_stats   = '0;
                     ctl.clr_one = ok_ff && (op_ff == OP_RESET_SLOT);
                  end
                  OP_SET_BUDGET: begin
                     res_bud    = val_ff;
                     ctl.bud_wr = ok_ff;
                  end
                  default: begin
                  end
               endcase
               if (!ok_ff) begin
                  res_stats = '0;
                  res_bud   = '0;
               end
            end
         end

         ST_AVG: begin
            wr_stats.count = rd_stats.count + DATA_W'(1);
            wr_stats.last  = val_ff;
            wr_stats.peak  = (val_ff > rd_stats.peak) ? val_ff : rd_stats.peak;
            if (wr_stats.count == DATA_W'(1)) begin
               wr_stats.avg = val_ff;
            end else if (ge_ff) begin
               wr_stats.avg = rd_stats.avg + avg_step;
            end else begin
               wr_stats.avg = rd_stats.avg - avg_step;
            end
            if (rd_bud != '0 && val_ff > rd_bud) begin
               wr_stats.overrun = rd_stats.overrun + DATA_W'(1);
            end
            res_stats = wr_stats;
            res_bud   = rd_bud;
            if (out_free) begin
               ctl.st_wr = 1'b1;
               load_rsp  = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // fetch the next slot while this one is folded in
            ctl.rd_en = 1'b1;
            rd_addr   = idx_ff + SLOT_W'(1);
            if (mask_sh[0]) begin
               act_in = act_ff + CNT_W'(1);
               tot_in = tot_ff + rd_stats.overrun;
               if (scan_over) begin
                  ovc_in = ovc_ff + CNT_W'(1);
               end
               if (rd_stats.last > mxl_ff) begin
                  mxl_in = rd_stats.last;
                  mxb_in = rd_bud;
               end
               if (excess > mxe_ff) begin
                  mxe_in = excess;
               end
            end
            if (idx_ff == SLOT_W'(SCAN_LAST)) begin
               state_in = ST_SUM;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         ST_SUM: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         rsp_data_in = {6'd0, mxe_ff, mxb_ff, mxl_ff, tot_ff, ovc_ff, act_ff,
                        res_bud, res_stats.overrun, res_stats.avg, res_stats.peak,
                        res_stats.last, res_stats.count};
         if (state_ff != ST_SUM) begin
            rsp_data_in[RSP_TDATA_W-1:6*DATA_W] = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration register
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign mask_in    = (csr_wr && csr_paddr[2] == CSR_ACTIVE_MASK[2]) ?
                       csr_pwdata[MASK_W-1:0] : mask_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_ACTIVE_MASK[2]) ?
                       {{(32-MASK_W){1'b0}}, mask_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      val_ff      <= val_in;
      ok_ff       <= ok_in;
      idx_ff      <= idx_in;
      diff_ff     <= diff_in;
      ge_ff       <= ge_in;
      act_ff      <= act_in;
      ovc_ff      <= ovc_in;
      tot_ff      <= tot_in;
      mxl_ff      <= mxl_in;
      mxb_ff      <= mxb_in;
      mxe_ff      <= mxe_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ttst_store #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_W    (SLOT_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_stats (wr_stats),
      .wr_bud   (val_ff),
      .rd_stats (rd_stats),
      .rd_bud   (rd_bud)
   );

   a_one_per_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while sequencer busy");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= SLOT_W'(SCAN_LAST))
      else $error("summary scan index past last slot");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> out_free)
      else $error("result loaded over a pending transaction");

   a_over_le_act: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> ovc_ff <= act_ff && act_ff <= CNT_W'(SCAN_N))
      else $error("summary counts inconsistent");

endmodule

>>> hw/rtl/ttst_store.sv
// Per-slot statistics and budget storage with one read and one write port.
// Stats and budget valid bits stand in for clearing; depends on ttst_pkg.
`timescale 1ns / 1ps

module ttst_store #(
   parameter int NUM_SLOTS = 16,
   parameter int SLOT_W    = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ttst_pkg::ttst_ctl_type    ctl,
   input  logic [SLOT_W-1:0]         rd_addr,
   input  logic [SLOT_W-1:0]         wr_addr,
   input  ttst_pkg::ttst_stats_type  wr_stats,
   input  logic [ttst_pkg::DATA_W-1:0] wr_bud,
   output ttst_pkg::ttst_stats_type  rd_stats,
   output logic [ttst_pkg::DATA_W-1:0] rd_bud
);
   import ttst_pkg::*;

   ttst_stats_type    stat_mem [NUM_SLOTS];
   logic [DATA_W-1:0] bud_mem  [NUM_SLOTS];

   logic [NUM_SLOTS-1:0] stat_vld_ff, stat_vld_in;
   logic [NUM_SLOTS-1:0] bud_vld_ff, bud_vld_in;
   ttst_stats_type       rd_stats_ff;
   logic [DATA_W-1:0]    rd_bud_ff;
   logic                 rd_svld_ff;
   logic                 rd_bvld_ff;

   always_ff @(posedge clock) begin
      if (ctl.st_wr) begin
         stat_mem[wr_addr] <= wr_stats;
      end
      if (ctl.bud_wr) begin
         bud_mem[wr_addr] <= wr_bud;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_stats_ff <= stat_mem[rd_addr];
         rd_bud_ff   <= bud_mem[rd_addr];
      end
   end

   always_comb begin
      stat_vld_in = stat_vld_ff;
      bud_vld_in  = bud_vld_ff;
      if (ctl.clr_all) begin
         stat_vld_in = '0;
      end
      if (ctl.clr_one) begin
         stat_vld_in[wr_addr] = 1'b0;
      end
      if (ctl.st_wr) begin
         stat_vld_in[wr_addr] = 1'b1;
      end
      if (ctl.bud_wr) begin
         bud_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_vld_ff <= '0;
         bud_vld_ff  <= '0;
         rd_svld_ff  <= 1'b0;
         rd_bvld_ff  <= 1'b0;
      end else begin
         stat_vld_ff <= stat_vld_in;
         bud_vld_ff  <= bud_vld_in;
         if (ctl.rd_en) begin
            rd_svld_ff <= stat_vld_ff[rd_addr];
            rd_bvld_ff <= bud_vld_ff[rd_addr];
         end
      end
   end

   // an entry never written since its last clear reads as zero
   assign rd_stats = rd_svld_ff ? rd_stats_ff : '0;
   assign rd_bud   = rd_bvld_ff ? rd_bud_ff : '0;

endmodule

>>> tb/task_timing_stats_table_tb.sv
// Self-checking testbench for task_timing_stats_table: directed and random requests,
// stall patterns on both stream channels, and active_mask writes over the APB port.
// Depends on ttst_pkg and the task_timing_stats_table RTL only.
`timescale 1ns / 1ps

module task_timing_stats_table_tb;
   import ttst_pkg::*;

   localparam int SLOTS = 16;
   localparam int LONG_HOLD = 400;
   localparam int ERR_PRINT_MAX = 40;
   // codes 6 and 7 are not defined; the block treats them as a slot read
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [3:0]        slot;
      logic [DATA_W-1:0] value;
   } stat_cmd_type;

   // laid out as rsp_tdata, highest field first
   typedef struct packed {
      logic [5:0]        pad;
      logic [31:0]       max_excess_time;
      logic [31:0]       budget_at_max_last;
      logic [31:0]       max_last_time;
      logic [31:0]       total_overruns;
      logic [4:0]        over_budget_slots;
      logic [4:0]        active_slots;
      logic [31:0]       budget_time;
      logic [31:0]       slot_overruns;
      logic [31:0]       average_time;
      logic [31:0]       peak_time;
      logic [31:0]       last_time;
      logic [31:0]       sample_count;
   } stats_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;   // slot[3:0], value[35:4], zero fill
   logic [OP_W-1:0]          req_tuser = '0;   // operation[2:0]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;        // fields as in stats_reply_type, low to high
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   // predicted table contents and register
   logic [31:0]   cnt_tab [SLOTS];
   logic [31:0]   last_tab [SLOTS];
   logic [31:0]   peak_tab [SLOTS];
   logic [31:0]   avg_tab [SLOTS];
   logic [31:0]   ovr_tab [SLOTS];
   logic [31:0]   bud_tab [SLOTS];
   logic [MASK_W-1:0] mask_model;

   stat_cmd_type     cmd_queue[$];
   stats_reply_type  reply_fifo[$];
   int unsigned   send_gap = 0;
   int unsigned   stall_left = 0;
   bit            calm = 1'b0;
   bit            hold_ask = 1'b0;
   int            errors = 0;
   int            replies_checked = 0;
   int            mask_settings = 1;
   int            op_seen [8];

   task_timing_stats_table #(.NUM_SLOTS(SLOTS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("task_timing_stats_table_tb NOT OK");
      $finish;
   end

   // Apply one request to the predicted tables and return the result it should give.
   function automatic stats_reply_type apply_to_stats(input logic [OP_W-1:0] op,
                                                      input logic [3:0] slot,
                                                      input logic [31:0] v);
      stats_reply_type r;
      logic [31:0]  ex;
      r = '0;
      if (op == OP_SUMMARY) begin
         for (int i = 0; i < SLOTS && i < MASK_W; i++) begin
            if (mask_model[i]) begin
               ex = '0;
               r.active_slots++;
               r.total_overruns += ovr_tab[i];
               if (bud_tab[i] != 0 && last_tab[i] > bud_tab[i]) begin
                  r.over_budget_slots++;
                  ex = last_tab[i] - bud_tab[i];
               end
               if (last_tab[i] > r.max_last_time) begin
                  r.max_last_time = last_tab[i];
                  r.budget_at_max_last = bud_tab[i];
               end
               if (ex > r.max_excess_time)
                  r.max_excess_time = ex;
            end
         end
         return r;
      end
      case (op)
         OP_RECORD: begin
            cnt_tab[slot] = cnt_tab[slot] + 1;
            last_tab[slot] = v;
            if (v > peak_tab[slot])
               peak_tab[slot] = v;
            // first sample seeds the average, later ones move it by a sixteenth
            if (cnt_tab[slot] == 1)
               avg_tab[slot] = v;
            else if (v >= avg_tab[slot])
               avg_tab[slot] = avg_tab[slot] + ((v - avg_tab[slot]) >> AVG_SHIFT);
            else
               avg_tab[slot] = avg_tab[slot] - ((avg_tab[slot] - v) >> AVG_SHIFT);
            if (bud_tab[slot] != 0 && v > bud_tab[slot])
               ovr_tab[slot] = ovr_tab[slot] + 1;
         end
         OP_RESET_SLOT: begin
            cnt_tab[slot] = '0; last_tab[slot] = '0; peak_tab[slot] = '0;
            avg_tab[slot] = '0; ovr_tab[slot] = '0;
         end
         OP_RESET_ALL: begin
            for (int i = 0; i < SLOTS; i++) begin
               cnt_tab[i] = '0; last_tab[i] = '0; peak_tab[i] = '0;
               avg_tab[i] = '0; ovr_tab[i] = '0;
            end
         end
         OP_SET_BUDGET: bud_tab[slot] = v;
         default: ;
      endcase
      r.sample_count  = cnt_tab[slot];
      r.last_time     = last_tab[slot];
      r.peak_time     = peak_tab[slot];
      r.average_time  = avg_tab[slot];
      r.slot_overruns = ovr_tab[slot];
      r.budget_time   = bud_tab[slot];
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly small times so that budgets, ties and overruns come up often.
   function automatic logic [31:0] pick_time();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(0, 400);
      if (r < 85)
         return $urandom_range(0, 65535);
      return $urandom;
   endfunction

   function automatic stat_cmd_type random_cmd();
      stat_cmd_type c;
      int unsigned r;
      r = $urandom_range(0, 99);
      c.slot = $urandom_range(0, SLOTS - 1);
      c.value = pick_time();
      if (r < 45)
         c.op = OP_RECORD;
      else if (r < 58)
         c.op = OP_READ_SLOT;
      else if (r < 70)
         c.op = OP_SUMMARY;
      else if (r < 83) begin
         c.op = OP_SET_BUDGET;
         if ($urandom_range(0, 4) == 0)
            c.value = '0;
      end else if (r < 90)
         c.op = OP_RESET_SLOT;
      else if (r < 93)
         c.op = OP_RESET_ALL;
      else if (r < 95)
         c.op = OP_SPARE_A;
      else if (r < 97)
         c.op = OP_SPARE_B;
      else begin
         c.op = OP_SUMMARY;
         c.value = $urandom;
      end
      return c;
   endfunction

   task automatic push_cmd(input logic [OP_W-1:0] op, input logic [3:0] slot,
                           input logic [31:0] v);
      stat_cmd_type c;
      c.op = op;
      c.slot = slot;
      c.value = v;
      cmd_queue.push_back(c);
   endtask

   task automatic push_random(input int n);
      for (int i = 0; i < n; i++)
         cmd_queue.push_back(random_cmd());
   endtask

   // Sample at the falling edge so the queues are settled.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (cmd_queue.size() != 0 || req_tvalid || reply_fifo.size() != 0);
   endtask

   task automatic csr_cycle(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_mask(input logic [MASK_W-1:0] m);
      logic [31:0] rd;
      wait_idle();
      csr_cycle(1'b1, CSR_ACTIVE_MASK, {16'h0, m}, rd);
      mask_model = m;
      mask_settings++;
      csr_cycle(1'b0, CSR_ACTIVE_MASK, '0, rd);
      if (rd[MASK_W-1:0] !== m) begin
         errors++;
         $display("%0t: active_mask readback expected %h actual %h", $time, m, rd);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= ERR_PRINT_MAX)
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Driver: predict at each accepted transaction, then offer the next pending item.
   always @(posedge clock) begin : driver
      stat_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            reply_fifo.push_back(apply_to_stats(req_tuser, req_tdata[3:0], req_tdata[35:4]));
            op_seen[req_tuser]++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered transaction
         end else if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (cmd_queue.size() != 0) begin
            nxt = cmd_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.op;
            req_tdata <= {4'h0, nxt.value, nxt.slot};
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, with an occasional long hold-off on request.
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_ask) begin
         hold_ask = 1'b0;
         stall_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin : monitor
      stats_reply_type got;
      stats_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (reply_fifo.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: %h", $time, rsp_tdata);
         end else begin
            want = reply_fifo.pop_front();
            replies_checked++;
            check_field("sample_count", want.sample_count, got.sample_count);
            check_field("last_time", want.last_time, got.last_time);
            check_field("peak_time", want.peak_time, got.peak_time);
            check_field("average_time", want.average_time, got.average_time);
            check_field("slot_overruns", want.slot_overruns, got.slot_overruns);
            check_field("budget_time", want.budget_time, got.budget_time);
            check_field("active_slots", want.active_slots, got.active_slots);
            check_field("over_budget_slots", want.over_budget_slots, got.over_budget_slots);
            check_field("total_overruns", want.total_overruns, got.total_overruns);
            check_field("max_last_time", want.max_last_time, got.max_last_time);
            check_field("budget_at_max_last", want.budget_at_max_last,
                        got.budget_at_max_last);
            check_field("max_excess_time", want.max_excess_time, got.max_excess_time);
            check_field("padding", want.pad, got.pad);
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         cnt_tab[i] = '0; last_tab[i] = '0; peak_tab[i] = '0;
         avg_tab[i] = '0; ovr_tab[i] = '0; bud_tab[i] = '0;
      end
      for (int i = 0; i < 8; i++)
         op_seen[i] = 0;
      mask_model = '1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: first sample, extreme times, average both ways, budgets
      push_cmd(OP_RECORD, 4'd0, 32'h0);
      push_cmd(OP_RECORD, 4'd0, 32'hFFFF_FFFF);
      push_cmd(OP_RECORD, 4'd0, 32'h10);
      push_cmd(OP_READ_SLOT, 4'd0, 32'h0);
      push_cmd(OP_SET_BUDGET, 4'd3, 32'd100);
      push_cmd(OP_RECORD, 4'd3, 32'd101);
      push_cmd(OP_RECORD, 4'd3, 32'd100);
      push_cmd(OP_RECORD, 4'd3, 32'hFFFF_FFFF);
      push_cmd(OP_SET_BUDGET, 4'd15, 32'hFFFF_FFFE);
      push_cmd(OP_RECORD, 4'd15, 32'hFFFF_FFFF);
      push_cmd(OP_SET_BUDGET, 4'd7, 32'h0);
      push_cmd(OP_RECORD, 4'd7, 32'd5000);
      push_cmd(OP_SUMMARY, 4'd0, 32'h0);
      // reset of one slot keeps its budget
      push_cmd(OP_RESET_SLOT, 4'd3, 32'h0);
      push_cmd(OP_READ_SLOT, 4'd3, 32'h0);
      push_cmd(OP_SPARE_A, 4'd7, 32'h1234_5678);
      push_cmd(OP_SPARE_B, 4'd15, 32'hFFFF_FFFF);
      push_cmd(OP_RESET_ALL, 4'd15, 32'h0);
      push_cmd(OP_SUMMARY, 4'd15, 32'hFFFF_FFFF);
      push_cmd(OP_RECORD, 4'd15, 32'h0);
      push_cmd(OP_SUMMARY, 4'd0, 32'h0);
      // equal last times: the lower slot wins the summary
      push_cmd(OP_RECORD, 4'd8, 32'h8000_0000);
      push_cmd(OP_RECORD, 4'd9, 32'h8000_0000);
      push_cmd(OP_SET_BUDGET, 4'd9, 32'h7000_0000);
      push_cmd(OP_SUMMARY, 4'd0, 32'h0);
      wait_idle();

      // long receiver hold-off while requests keep coming
      hold_ask = 1'b1;
      push_random(200);

      set_mask('0);
      calm = 1'b1;
      push_random(150);

      set_mask(16'h0001);
      calm = 1'b0;
      push_random(75);
      wait_idle();            // sender pause until all results are in
      push_random(75);

      set_mask(16'h8000);
      push_random(150);

      for (int k = 0; k < 3; k++) begin
         set_mask($urandom_range(0, 65535));
         push_random(130);
      end

      set_mask('1);
      hold_ask = 1'b1;
      push_random(200);

      wait_idle();
      repeat (40) @(posedge clock);
      $display("covered %0d record, %0d reset slot, %0d reset all, %0d set budget,",
               op_seen[OP_RECORD], op_seen[OP_RESET_SLOT], op_seen[OP_RESET_ALL],
               op_seen[OP_SET_BUDGET]);
      $display("%0d read, %0d summary, %0d undefined-op requests; %0d results, %0d masks",
               op_seen[OP_READ_SLOT], op_seen[OP_SUMMARY],
               op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B], replies_checked, mask_settings);
      if (errors == 0) begin
         $display("task_timing_stats_table_tb OK");
      end else begin
         $display("task_timing_stats_table_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ttst_pkg.sv
hw/rtl/ttst_store.sv
hw/rtl/task_timing_stats_table.sv
tb/task_timing_stats_table_tb.sv
